// ===== hw/rtl/klhr_pkg.sv =====
// Package for the key line hold and ring controller.
// Holds register widths, reset values, register indexes and shared structs.
// Depends on nothing.
`default_nettype none

package klhr_pkg;

    localparam int LIMIT_W      = 8;
    localparam int LAMP_PAT_W   = 12;
    localparam int BELL_PAT_W   = 6;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int MODE_W       = 3;

    localparam int LAMP_SEL_W   = 4;
    localparam int BELL_SEL_W   = 3;

    localparam int DEF_LAMP_CADENCE_STEPS = 12;
    localparam int DEF_BELL_CADENCE_STEPS = 6;

    localparam logic [LIMIT_W-1:0]    RST_DEBOUNCE_LIMIT = 8'd10;
    localparam logic [LAMP_PAT_W-1:0] RST_HOLD_LAMP_PAT  = 12'd4030;
    localparam logic [LAMP_PAT_W-1:0] RST_RING_LAMP_PAT  = 12'd4032;
    localparam logic [BELL_PAT_W-1:0] RST_BELL_PAT       = 6'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LAMP_PAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING_LAMP_PAT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BELL_PAT       = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RINGING = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENTER   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IN_USE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HELD    = 3'd4;

    typedef logic [LAMP_SEL_W-1:0] t_lamp_sel;
    typedef logic [BELL_SEL_W-1:0] t_bell_sel;

    typedef struct packed {
        logic line_lvl;
        logic ring_lvl;
        logic a_lead;
    } t_levels;

    typedef struct packed {
        logic [LAMP_PAT_W-1:0] hold_lamp_pat;
        logic [LAMP_PAT_W-1:0] ring_lamp_pat;
        logic [BELL_PAT_W-1:0] bell_pat;
    } t_patterns;

    typedef struct packed {
        logic              hold_relay;
        logic              ring_relay;
        logic              lamp_drive;
        logic [MODE_W-1:0] line_mode;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/klhr_debounce.sv =====
// Debounce of one raw input level with a saturating consecutive-mismatch counter.
// Depends on klhr_pkg.
`default_nettype none

module klhr_debounce
    import klhr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_level,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output logic                    o_level
);

    logic               r_latch;
    logic               n_latch;
    logic [LIMIT_W-1:0] r_count;
    logic [LIMIT_W-1:0] n_count;

    always_comb begin
        n_latch = r_latch;
        n_count = r_count;
        if (i_level != r_latch) begin
            if (r_count > i_limit) begin
                n_latch = i_level;
                n_count = '0;
            end else if (r_count != {LIMIT_W{1'b1}}) begin
                n_count = r_count + LIMIT_W'(1);
            end
        end else begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_latch <= n_latch;
            r_count <= n_count;
        end
    end

    // The mode logic sees the level as updated by this poll.
    assign o_level = n_latch;

endmodule

`default_nettype wire

// ===== hw/rtl/klhr_step_ctr.sv =====
// Cadence step counter that advances on a tick and wraps at its step count.
// Depends on klhr_pkg.
`default_nettype none

module klhr_step_ctr
    import klhr_pkg::*;
#(
    parameter int STEPS = DEF_LAMP_CADENCE_STEPS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_tick,
    output logic [$clog2(STEPS)-1:0]      o_idx
);

    localparam int W = $clog2(STEPS);

    logic [W-1:0] r_idx;
    logic [W-1:0] n_idx;
    logic [W:0]   sum;

    always_comb begin
        sum   = {1'b0, r_idx} + (W+1)'(1);
        n_idx = r_idx;
        if (i_tick) begin
            n_idx = (sum >= (W+1)'(STEPS)) ? '0 : sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_en) begin
            r_idx <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

`default_nettype wire

// ===== hw/rtl/klhr_mode.sv =====
// Line mode decision, hold flag and relay and lamp drive with cadence lookup.
// Depends on klhr_pkg.
`default_nettype none

module klhr_mode
    import klhr_pkg::*;
#(
    parameter int LAMP_IDX_W = LAMP_SEL_W,
    parameter int BELL_IDX_W = BELL_SEL_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_levels               i_levels,
    input  wire t_patterns             i_pats,
    input  wire logic [LAMP_IDX_W-1:0] i_lamp_idx,
    input  wire logic [BELL_IDX_W-1:0] i_bell_idx,
    output t_result                    o_result
);

    logic                          r_hold_flag;
    logic                          n_hold_flag;
    logic [(1<<LAMP_SEL_W)-1:0]    hold_pat_ext;
    logic [(1<<LAMP_SEL_W)-1:0]    ring_pat_ext;
    logic [(1<<BELL_SEL_W)-1:0]    bell_pat_ext;
    t_lamp_sel                     lamp_sel;
    t_bell_sel                     bell_sel;
    logic                          hold_lamp_now;
    logic                          ring_lamp_now;
    logic                          bell_now;

    // Steps past the end of a pattern read zero through the extension.
    always_comb begin
        hold_pat_ext  = (1<<LAMP_SEL_W)'(i_pats.hold_lamp_pat);
        ring_pat_ext  = (1<<LAMP_SEL_W)'(i_pats.ring_lamp_pat);
        bell_pat_ext  = (1<<BELL_SEL_W)'(i_pats.bell_pat);
        lamp_sel      = t_lamp_sel'(i_lamp_idx);
        bell_sel      = t_bell_sel'(i_bell_idx);
        hold_lamp_now = hold_pat_ext[lamp_sel];
        ring_lamp_now = ring_pat_ext[lamp_sel];
        bell_now      = bell_pat_ext[bell_sel];
    end

    always_comb begin
        o_result    = '0;
        n_hold_flag = 1'b0;
        if (i_levels.line_lvl) begin
            if (r_hold_flag) begin
                o_result.hold_relay = !i_levels.a_lead;
                o_result.lamp_drive = hold_lamp_now;
                o_result.line_mode  = MODE_HELD;
            end else if (i_levels.a_lead) begin
                o_result.lamp_drive = 1'b1;
                o_result.line_mode  = MODE_IN_USE;
            end else begin
                o_result.hold_relay = 1'b1;
                o_result.lamp_drive = hold_lamp_now;
                o_result.line_mode  = MODE_ENTER;
                n_hold_flag         = 1'b1;
            end
        end else if (i_levels.ring_lvl) begin
            o_result.ring_relay = bell_now;
            o_result.lamp_drive = ring_lamp_now;
            o_result.line_mode  = MODE_RINGING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_flag <= 1'b0;
        end else if (i_en) begin
            r_hold_flag <= n_hold_flag;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/key_line_hold_ring_controller_unit.sv =====
// Top level of the key line hold and ring controller for one telephone line.
// Depends on klhr_pkg, klhr_debounce, klhr_step_ctr and klhr_mode.
//
//   Channel  Direction  Handshake                 Payload
//   in       to block   i_in_valid / o_in_stall   3 raw levels, lamp and bell ticks
//   out      from block o_out_valid / i_out_stall hold, ring, lamp, line mode
//   cfg      to block   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One poll per cycle unless the input is stalled: state and the output register
// update on the accepting edge, so the result is offered from the next cycle on.
// The only storage between the channels is the output register, so a transfer
// is taken whenever that register is empty or is being emptied in the same cycle.
// Reset is synchronous and active low; configuration registers return to their
// defaults and all debounce, hold and cadence state clears.
`default_nettype none

module key_line_hold_ring_controller_unit
    import klhr_pkg::*;
#(
    parameter int LAMP_CADENCE_STEPS = DEF_LAMP_CADENCE_STEPS,
    parameter int BELL_CADENCE_STEPS = DEF_BELL_CADENCE_STEPS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_line_detect_raw,
    input  wire logic                  i_ring_detect_raw,
    input  wire logic                  i_a_lead_raw,
    input  wire logic                  i_lamp_tick,
    input  wire logic                  i_bell_tick,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_hold_relay,
    output logic                       o_ring_relay,
    output logic                       o_lamp_drive,
    output logic [MODE_W-1:0]          o_line_mode,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAMP_IDX_W = $clog2(LAMP_CADENCE_STEPS);
    localparam int BELL_IDX_W = $clog2(BELL_CADENCE_STEPS);

    logic [LIMIT_W-1:0]    r_limit;
    t_patterns             r_pats;
    logic                  in_xfer;
    t_levels               levels;
    logic [LAMP_IDX_W-1:0] lamp_idx;
    logic [BELL_IDX_W-1:0] bell_idx;
    t_result               result;
    t_result               r_result;
    logic                  r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit              <= RST_DEBOUNCE_LIMIT;
            r_pats.hold_lamp_pat <= RST_HOLD_LAMP_PAT;
            r_pats.ring_lamp_pat <= RST_RING_LAMP_PAT;
            r_pats.bell_pat      <= RST_BELL_PAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE_LIMIT: r_limit              <= i_cfg_data[LIMIT_W-1:0];
                REG_HOLD_LAMP_PAT:  r_pats.hold_lamp_pat <= i_cfg_data[LAMP_PAT_W-1:0];
                REG_RING_LAMP_PAT:  r_pats.ring_lamp_pat <= i_cfg_data[LAMP_PAT_W-1:0];
                REG_BELL_PAT:       r_pats.bell_pat      <= i_cfg_data[BELL_PAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    klhr_debounce u_deb_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_level (i_line_detect_raw),
        .i_limit (r_limit),
        .o_level (levels.line_lvl)
    );

    klhr_debounce u_deb_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_level (i_ring_detect_raw),
        .i_limit (r_limit),
        .o_level (levels.ring_lvl)
    );

    klhr_debounce u_deb_a_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_level (i_a_lead_raw),
        .i_limit (r_limit),
        .o_level (levels.a_lead)
    );

    klhr_step_ctr #(
        .STEPS (LAMP_CADENCE_STEPS)
    ) u_lamp_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_tick  (i_lamp_tick),
        .o_idx   (lamp_idx)
    );

    klhr_step_ctr #(
        .STEPS (BELL_CADENCE_STEPS)
    ) u_bell_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_tick  (i_bell_tick),
        .o_idx   (bell_idx)
    );

    klhr_mode #(
        .LAMP_IDX_W (LAMP_IDX_W),
        .BELL_IDX_W (BELL_IDX_W)
    ) u_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (in_xfer),
        .i_levels   (levels),
        .i_pats     (r_pats),
        .i_lamp_idx (lamp_idx),
        .i_bell_idx (bell_idx),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hold_relay = r_result.hold_relay;
    assign o_ring_relay = r_result.ring_relay;
    assign o_lamp_drive = r_result.lamp_drive;
    assign o_line_mode  = r_result.line_mode;

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted transfer did not load the output register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with an empty output register");

    a_ring_only_ringing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.ring_relay) |-> (r_result.line_mode == MODE_RINGING))
        else $error("ring relay driven outside the ringing mode");

    a_in_use_lamp_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.line_mode == MODE_IN_USE) |->
        (r_result.lamp_drive && !r_result.hold_relay))
        else $error("in use mode with lamp off or hold relay energized");

    a_enter_then_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && result.line_mode == MODE_ENTER) ##1 in_xfer |->
        (result.line_mode == MODE_HELD || result.line_mode == MODE_IDLE ||
         result.line_mode == MODE_RINGING))
        else $error("entering hold not followed by the held mode or line loss");

endmodule

`default_nettype wire
